// File: rtl/e2q_pkg.sv
// Shared constants, types and arithmetic helpers for the Euler angle to quaternion block.
package e2q_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int FIELD_W    = 16;
  localparam int OUT_W      = FRAC_BITS + 2;

  // Q30 working format
  localparam int QB  = 30;
  localparam int XW  = QB;
  localparam int TW  = QB + 1;
  localparam int SCW = QB + 2;
  localparam int RS  = QB + 1;
  localparam int KW  = 8;

  localparam logic [TW-1:0] ONE_Q   = {1'b1, {QB{1'b0}}};
  localparam logic [33:0]   PI_Q32  = 34'h3243F6A88;

  localparam int SIN_TERMS   = 5;
  localparam int COS_TERMS   = 6;
  localparam int TRIG_STAGES = 2 + 3 * COS_TERMS;
  localparam int STAGES      = TRIG_STAGES + 3;

  localparam logic [KW-1:0] SIN_DEN [SIN_TERMS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [KW-1:0] COS_DEN [COS_TERMS] =
    '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  localparam logic [63:0] RECIP_ONE = 64'd1 << RS;

  // floor(2^31 / k): estimate is exact or one short for u < 2^31
  localparam logic [TW-1:0] SIN_RECIP [SIN_TERMS] = '{
    TW'(RECIP_ONE / 64'd110), TW'(RECIP_ONE / 64'd72), TW'(RECIP_ONE / 64'd42),
    TW'(RECIP_ONE / 64'd20), TW'(RECIP_ONE / 64'd6)};
  localparam logic [TW-1:0] COS_RECIP [COS_TERMS] = '{
    TW'(RECIP_ONE / 64'd132), TW'(RECIP_ONE / 64'd90), TW'(RECIP_ONE / 64'd56),
    TW'(RECIP_ONE / 64'd30), TW'(RECIP_ONE / 64'd12), TW'(RECIP_ONE / 64'd2)};

  localparam logic signed [2*SCW-1:0] MUL_RND = 64'sd1 <<< (QB - 1);
  localparam logic signed [SCW:0]     FIN_RND = 33'sd1 <<< (QB - FRAC_BITS - 1);
  localparam logic signed [SCW:0]     FIN_LIM = 33'sd1 <<< FRAC_BITS;

  typedef struct packed {
    logic signed [SCW-1:0] s;
    logic signed [SCW-1:0] c;
  } trig_t;

  // unsigned Q30 product, rounded
  function automatic logic [XW-1:0] umul_q(logic [XW-1:0] a, logic [TW-1:0] b);
    logic [XW+TW-1:0] p;
    p = (XW+TW)'(a) * (XW+TW)'(b);
    p = p + ((XW+TW)'(1) << (QB - 1));
    return p[QB +: XW];
  endfunction

  function automatic logic [XW-1:0] div_est(logic [XW-1:0] u, logic [TW-1:0] recip);
    logic [XW+TW-1:0] p;
    p = (XW+TW)'(u) * (XW+TW)'(recip);
    return p[RS +: XW];
  endfunction

  function automatic logic [XW-1:0] div_fix(logic [XW-1:0] u, logic [XW-1:0] qe,
                                            logic [KW-1:0] k);
    logic [XW+KW-1:0] p;
    logic [XW-1:0]    rem;
    p   = (XW+KW)'(qe) * (XW+KW)'(k);
    rem = u - p[XW-1:0];
    return qe + XW'(rem >= XW'(k));
  endfunction

  // signed Q30 product, round half up
  function automatic logic signed [SCW-1:0] smul_q(logic signed [SCW-1:0] a,
                                                   logic signed [SCW-1:0] b);
    logic signed [2*SCW-1:0] p;
    p = a * b;
    p = p + MUL_RND;
    return p[QB +: SCW];
  endfunction

  // Q30 sum to output format with saturation
  function automatic logic [OUT_W-1:0] finish(logic signed [SCW:0] v);
    logic signed [SCW:0] t;
    t = v + FIN_RND;
    t = t >>> (QB - FRAC_BITS);
    if (t > FIN_LIM) begin
      t = FIN_LIM;
    end else if (t < -FIN_LIM) begin
      t = -FIN_LIM;
    end
    return t[OUT_W-1:0];
  endfunction

endpackage

// File: rtl/e2q_trig.sv
// Pipelined sine and cosine of a half binary angle, Q30 series evaluation.
module e2q_trig (
  input  logic                                clk,
  input  logic [e2q_pkg::TRIG_STAGES-1:0]     en,
  input  logic [e2q_pkg::FIELD_W-1:0]         angle,
  output e2q_pkg::trig_t                      res
);

  localparam int AB   = e2q_pkg::ANGLE_BITS;
  localparam int NS   = e2q_pkg::TRIG_STAGES;
  localparam int XW   = e2q_pkg::XW;
  localparam int TW   = e2q_pkg::TW;
  localparam int SCW  = e2q_pkg::SCW;
  localparam int NSIN = e2q_pkg::SIN_TERMS;
  localparam int NCOS = e2q_pkg::COS_TERMS;
  localparam int SF   = 2 + 3 * NSIN;
  localparam int PW   = 34 + AB;

  localparam logic [AB-1:0] ANG_HALF    = AB'(1) << (AB - 1);
  localparam logic [AB-1:0] ANG_QUARTER = AB'(1) << (AB - 2);

  logic          hq0;
  logic          sw0;
  logic [AB-1:0] r0;
  logic [AB-1:0] rr0;
  logic [PW-1:0] xp0;

  logic [XW-1:0] x_r  [NS];
  logic [XW-1:0] x2_r [1:NS-1];
  logic          hq_r [NS];
  logic          sw_r [NS];

  logic [XW-1:0] cp_r [NCOS];
  logic [XW-1:0] cu_r [NCOS];
  logic [XW-1:0] cq_r [NCOS];
  logic [TW-1:0] ct_r [NCOS];

  logic [XW-1:0] sp_r [NSIN];
  logic [XW-1:0] su_r [NSIN];
  logic [XW-1:0] sq_r [NSIN];
  logic [TW-1:0] st_r [NSIN];

  logic [XW-1:0] sv_r [SF:NS-1];

  logic signed [SCW-1:0] s_pre;
  logic signed [SCW-1:0] c_pre;

  // fold into the first octant of the half angle
  assign hq0 = angle[AB-1];
  assign r0  = {1'b0, angle[AB-2:0]};
  assign sw0 = r0 > ANG_QUARTER;
  assign rr0 = sw0 ? (ANG_HALF - r0) : r0;
  assign xp0 = PW'(e2q_pkg::PI_Q32) * PW'(rr0) + (PW'(1) << (AB + 1));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0]  <= xp0[AB+2 +: XW];
      hq_r[0] <= hq0;
      sw_r[0] <= sw0;
    end
    if (en[1]) begin
      x2_r[1] <= e2q_pkg::umul_q(x_r[0], TW'(x_r[0]));
    end
  end

  for (genvar st = 1; st < NS; st++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en[st]) begin
        x_r[st]  <= x_r[st-1];
        hq_r[st] <= hq_r[st-1];
        sw_r[st] <= sw_r[st-1];
      end
    end
    if (st >= 2) begin : g_x2
      always_ff @(posedge clk) begin
        if (en[st]) begin
          x2_r[st] <= x2_r[st-1];
        end
      end
    end
  end

  // each term: multiply, divide estimate, divide fix and subtract
  for (genvar j = 0; j < NCOS; j++) begin : g_cos
    localparam int SA = 2 + 3 * j;
    logic [TW-1:0] t_in;
    logic [XW-1:0] u_c;
    if (j == 0) begin : g_first
      assign t_in = e2q_pkg::ONE_Q;
    end else begin : g_next
      assign t_in = ct_r[j-1];
    end
    assign u_c = cp_r[j] + XW'(e2q_pkg::COS_DEN[j] >> 1);
    always_ff @(posedge clk) begin
      if (en[SA]) begin
        cp_r[j] <= e2q_pkg::umul_q(x2_r[SA-1], t_in);
      end
      if (en[SA+1]) begin
        cu_r[j] <= u_c;
        cq_r[j] <= e2q_pkg::div_est(u_c, e2q_pkg::COS_RECIP[j]);
      end
      if (en[SA+2]) begin
        ct_r[j] <= e2q_pkg::ONE_Q -
                   TW'(e2q_pkg::div_fix(cu_r[j], cq_r[j], e2q_pkg::COS_DEN[j]));
      end
    end
  end

  for (genvar j = 0; j < NSIN; j++) begin : g_sin
    localparam int SA = 2 + 3 * j;
    logic [TW-1:0] t_in;
    logic [XW-1:0] u_c;
    if (j == 0) begin : g_first
      assign t_in = e2q_pkg::ONE_Q;
    end else begin : g_next
      assign t_in = st_r[j-1];
    end
    assign u_c = sp_r[j] + XW'(e2q_pkg::SIN_DEN[j] >> 1);
    always_ff @(posedge clk) begin
      if (en[SA]) begin
        sp_r[j] <= e2q_pkg::umul_q(x2_r[SA-1], t_in);
      end
      if (en[SA+1]) begin
        su_r[j] <= u_c;
        sq_r[j] <= e2q_pkg::div_est(u_c, e2q_pkg::SIN_RECIP[j]);
      end
      if (en[SA+2]) begin
        st_r[j] <= e2q_pkg::ONE_Q -
                   TW'(e2q_pkg::div_fix(su_r[j], sq_r[j], e2q_pkg::SIN_DEN[j]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[SF]) begin
      sv_r[SF] <= e2q_pkg::umul_q(x_r[SF-1], st_r[NSIN-1]);
    end
  end

  for (genvar st = SF + 1; st < NS; st++) begin : g_sv
    always_ff @(posedge clk) begin
      if (en[st]) begin
        sv_r[st] <= sv_r[st-1];
      end
    end
  end

  // undo octant fold, then the second quadrant
  always_comb begin
    if (sw_r[NS-1]) begin
      s_pre = $signed({1'b0, ct_r[NCOS-1]});
      c_pre = $signed({2'b00, sv_r[NS-1]});
    end else begin
      s_pre = $signed({2'b00, sv_r[NS-1]});
      c_pre = $signed({1'b0, ct_r[NCOS-1]});
    end
    if (hq_r[NS-1]) begin
      res.s = c_pre;
      res.c = -s_pre;
    end else begin
      res.s = s_pre;
      res.c = c_pre;
    end
  end

endmodule

// File: rtl/euler_to_quaternion_top.sv
// Yaw, pitch and roll binary angles to a unit quaternion in signed Q1.14.
// Pipeline: 23 register stages; a result shows on m_tvalid once its request has passed through all of them.
// Throughput: one request per cycle while the output is not stalled; every multiply and divide step has its own stage.
// Stalls: a stage empties into the next when that one is free, so bubbles close up.
// Reset clears the stage valid bits only; s_tready is high straight out of reset.
module euler_to_quaternion_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // yaw_angle, pitch_angle, roll_angle
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // quat_x, quat_y, quat_z, quat_w
);

  localparam int NS    = e2q_pkg::STAGES;
  localparam int TS    = e2q_pkg::TRIG_STAGES;
  localparam int SCW   = e2q_pkg::SCW;
  localparam int OUT_W = e2q_pkg::OUT_W;
  localparam int FW    = e2q_pkg::FIELD_W;

  localparam logic signed [OUT_W-1:0] OUT_LIM = OUT_W'(1 << e2q_pkg::FRAC_BITS);

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  e2q_pkg::trig_t ty;
  e2q_pkg::trig_t tp;
  e2q_pkg::trig_t tr;

  logic signed [SCW-1:0] cycr, sysr, cysr, sycr, cp, sp;
  logic signed [SCW-1:0] w1, w2, x1, x2, y1, y2, z1, z2;
  logic [OUT_W-1:0]      quat_x, quat_y, quat_z, quat_w;

  for (genvar i = 0; i < NS; i++) begin : g_en
    assign en[i] = m_tready || !(&v[NS-1:i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= s_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = v[NS-1];

  e2q_trig u_yaw (
    .clk   (clk),
    .en    (en[TS-1:0]),
    .angle (s_tdata[FW-1:0]),
    .res   (ty)
  );

  e2q_trig u_pitch (
    .clk   (clk),
    .en    (en[TS-1:0]),
    .angle (s_tdata[2*FW-1:FW]),
    .res   (tp)
  );

  e2q_trig u_roll (
    .clk   (clk),
    .en    (en[TS-1:0]),
    .angle (s_tdata[3*FW-1:2*FW]),
    .res   (tr)
  );

  // yaw-roll pairs, each shared by two of the four components
  always_ff @(posedge clk) begin
    if (en[TS]) begin
      cycr <= e2q_pkg::smul_q(ty.c, tr.c);
      sysr <= e2q_pkg::smul_q(ty.s, tr.s);
      cysr <= e2q_pkg::smul_q(ty.c, tr.s);
      sycr <= e2q_pkg::smul_q(ty.s, tr.c);
      cp   <= tp.c;
      sp   <= tp.s;
    end
  end

  always_ff @(posedge clk) begin
    if (en[TS+1]) begin
      w1 <= e2q_pkg::smul_q(cycr, cp);
      w2 <= e2q_pkg::smul_q(sysr, sp);
      x1 <= e2q_pkg::smul_q(cysr, cp);
      x2 <= e2q_pkg::smul_q(sycr, sp);
      y1 <= e2q_pkg::smul_q(cycr, sp);
      y2 <= e2q_pkg::smul_q(sysr, cp);
      z1 <= e2q_pkg::smul_q(sycr, cp);
      z2 <= e2q_pkg::smul_q(cysr, sp);
    end
  end

  always_ff @(posedge clk) begin
    if (en[TS+2]) begin
      quat_x <= e2q_pkg::finish((SCW+1)'(x1) - (SCW+1)'(x2));
      quat_y <= e2q_pkg::finish((SCW+1)'(y1) + (SCW+1)'(y2));
      quat_z <= e2q_pkg::finish((SCW+1)'(z1) - (SCW+1)'(z2));
      quat_w <= e2q_pkg::finish((SCW+1)'(w1) + (SCW+1)'(w2));
    end
  end

  assign m_tdata = {quat_w, quat_z, quat_y, quat_x};

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v[0])
    else $error("accepted request not captured in first stage");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (&v) && !m_tready)
    else $error("input held off with a free stage");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(quat_x) <= OUT_LIM) && ($signed(quat_x) >= -OUT_LIM) &&
                 ($signed(quat_y) <= OUT_LIM) && ($signed(quat_y) >= -OUT_LIM) &&
                 ($signed(quat_z) <= OUT_LIM) && ($signed(quat_z) >= -OUT_LIM) &&
                 ($signed(quat_w) <= OUT_LIM) && ($signed(quat_w) >= -OUT_LIM))
    else $error("quaternion component beyond unit range");

endmodule
